@@ hdl/trcm_pkg.sv @@
// Shared widths, result codes and the classification record for the triangle unit.
package trcm_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned MagW    = CoordW;
  localparam int unsigned SqW     = 2 * MagW;
  localparam int unsigned SideW   = SqW + 1;
  localparam int unsigned ProdW   = 2 * DiffW;
  localparam int unsigned CrossW  = ProdW + 1;
  localparam int unsigned RootW   = (SideW + 1) / 2;
  localparam int unsigned RadW    = 2 * RootW;
  localparam int unsigned RemW    = RootW + 1;
  localparam int unsigned PerimW  = 19;
  localparam int unsigned AreaW   = 32;
  localparam int unsigned KindW   = 3;
  // front end stages and root stages
  localparam int unsigned FrontStages = 4;
  localparam int unsigned RootStages  = RootW;

  typedef enum logic [KindW-1:0] {
    KIND_DEGENERATE  = 3'd0,
    KIND_EQUILATERAL = 3'd1,
    KIND_RIGHT_ISO   = 3'd2,
    KIND_ISOSCELES   = 3'd3,
    KIND_RIGHT       = 3'd4,
    KIND_SCALENE     = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [AreaW-1:0]  area;
  } cls_t;

endpackage

@@ hdl/trcm_front.sv @@
// Front end: side and cross terms, squares, sums and classification in four stages.
module trcm_front import trcm_pkg::*; (
  input  logic                        clk_i,
  input  logic [FrontStages-1:0]      en_i,
  input  logic signed [CoordW-1:0]    ax_i,
  input  logic signed [CoordW-1:0]    ay_i,
  input  logic signed [CoordW-1:0]    bx_i,
  input  logic signed [CoordW-1:0]    by_i,
  input  logic signed [CoordW-1:0]    cx_i,
  input  logic signed [CoordW-1:0]    cy_i,
  output logic [SideW-1:0]            side_ab_o,
  output logic [SideW-1:0]            side_bc_o,
  output logic [SideW-1:0]            side_ca_o,
  output cls_t                        cls_o
);

  // stage 1: coordinate differences
  logic [MagW-1:0] mag_q [6];
  logic [MagW-1:0] mag_d [6];
  logic signed [DiffW-1:0] cd_q [4];
  logic signed [DiffW-1:0] cd_d [4];
  logic signed [DiffW-1:0] sd [6];

  always_comb begin
    sd[0] = DiffW'(bx_i) - DiffW'(ax_i);
    sd[1] = DiffW'(by_i) - DiffW'(ay_i);
    sd[2] = DiffW'(cx_i) - DiffW'(bx_i);
    sd[3] = DiffW'(cy_i) - DiffW'(by_i);
    sd[4] = DiffW'(cx_i) - DiffW'(ax_i);
    sd[5] = DiffW'(cy_i) - DiffW'(ay_i);
    for (int i = 0; i < 6; i++) begin
      mag_d[i] = sd[i][DiffW-1] ? MagW'(-sd[i]) : MagW'(sd[i]);
    end
    cd_d[0] = sd[0];
    cd_d[1] = sd[5];
    cd_d[2] = sd[1];
    cd_d[3] = sd[4];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag_q <= mag_d;
      cd_q  <= cd_d;
    end
  end

  // stage 2: squares and cross products
  logic [SqW-1:0]          sq_q [6];
  logic signed [ProdW-1:0] pr_q [2];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 6; i++) begin
        sq_q[i] <= mag_q[i] * mag_q[i];
      end
      pr_q[0] <= cd_q[0] * cd_q[1];
      pr_q[1] <= cd_q[2] * cd_q[3];
    end
  end

  // stage 3: squared sides and cross product
  logic [SideW-1:0]         ab_q, bc_q, ca_q;
  logic signed [CrossW-1:0] cross_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ab_q    <= SideW'(sq_q[0]) + SideW'(sq_q[1]);
      bc_q    <= SideW'(sq_q[2]) + SideW'(sq_q[3]);
      ca_q    <= SideW'(sq_q[4]) + SideW'(sq_q[5]);
      cross_q <= CrossW'(pr_q[0]) - CrossW'(pr_q[1]);
    end
  end

  // stage 4: classification and area
  logic [SideW:0]    s_ab_bc, s_ab_ca, s_bc_ca;
  logic              right, eq_ab_bc, eq_bc_ca, eq_ab_ca;
  logic [CrossW-1:0] cross_mag;
  cls_t              cls_d;

  always_comb begin
    s_ab_bc   = {1'b0, ab_q} + {1'b0, bc_q};
    s_ab_ca   = {1'b0, ab_q} + {1'b0, ca_q};
    s_bc_ca   = {1'b0, bc_q} + {1'b0, ca_q};
    right     = (s_ab_bc == {1'b0, ca_q}) || (s_ab_ca == {1'b0, bc_q}) ||
                (s_bc_ca == {1'b0, ab_q});
    eq_ab_bc  = (ab_q == bc_q);
    eq_bc_ca  = (bc_q == ca_q);
    eq_ab_ca  = (ab_q == ca_q);
    cross_mag = cross_q[CrossW-1] ? CrossW'(-cross_q) : CrossW'(cross_q);
    cls_d.area = cross_mag[AreaW:1];
    if (cross_q == '0) begin
      cls_d.kind = KIND_DEGENERATE;
      cls_d.area = '0;
    end else if (eq_ab_bc && eq_bc_ca) begin
      cls_d.kind = KIND_EQUILATERAL;
    end else if (eq_ab_bc || eq_bc_ca || eq_ab_ca) begin
      cls_d.kind = right ? KIND_RIGHT_ISO : KIND_ISOSCELES;
    end else begin
      cls_d.kind = right ? KIND_RIGHT : KIND_SCALENE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      side_ab_o <= ab_q;
      side_bc_o <= bc_q;
      side_ca_o <= ca_q;
      cls_o     <= cls_d;
    end
  end

endmodule

@@ hdl/trcm_isqrt.sv @@
// Pipelined restoring integer square root, one root bit per stage.
module trcm_isqrt import trcm_pkg::*; (
  input  logic                   clk_i,
  input  logic [RootStages-1:0]  en_i,
  input  logic [SideW-1:0]       val_i,
  output logic [RootW-1:0]       root_o
);

  logic [RadW-1:0]  rad_q  [RootStages];
  logic [RemW-1:0]  rem_q  [RootStages];
  logic [RootW-1:0] root_q [RootStages];

  for (genvar s = 0; s < RootStages; s++) begin : g_stage
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW+1:0]  trial_rem;
    logic [RemW+1:0]  trial_sub;

    if (s == 0) begin : g_first
      assign rad_in  = RadW'(val_i);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // bring down the next bit pair and try subtracting 4q+1
    assign trial_rem = {rem_in, rad_in[RadW-1 -: 2]};
    assign trial_sub = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rad_q[s] <= rad_in << 2;
        if (trial_rem >= trial_sub) begin
          rem_q[s]  <= RemW'(trial_rem - trial_sub);
          root_q[s] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[s]  <= RemW'(trial_rem);
          root_q[s] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RootStages-1];

endmodule

@@ hdl/triangle_classify_measure_unit.sv @@
// Top level of the triangle classifier: stage control, root units and result register.
// Takes one triangle (three Q12.4 points) per cycle while in_ready_o is high and
// returns its kind, perimeter (sum of truncated side lengths) and area (half the
// absolute cross product). A word passes 22 register stages: four front-end stages
// (differences, squares, sums, classification), seventeen square-root stages of one
// root bit each, and the result register. Every stage holds its word under its own
// valid bit, so a stall at the output only backs up the stages that are full;
// bubbles are squeezed out.
module triangle_classify_measure_unit import trcm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [CoordW-1:0]  ax_i,
  input  logic signed [CoordW-1:0]  ay_i,
  input  logic signed [CoordW-1:0]  bx_i,
  input  logic signed [CoordW-1:0]  by_i,
  input  logic signed [CoordW-1:0]  cx_i,
  input  logic signed [CoordW-1:0]  cy_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [KindW-1:0]          kind_o,
  output logic [PerimW-1:0]         perimeter_o,
  output logic [AreaW-1:0]          area_o
);

  localparam int unsigned NumStages = FrontStages + RootStages + 1;

  // stage valids and load enables
  logic [NumStages-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

  // front end
  logic [SideW-1:0] side_ab, side_bc, side_ca;
  cls_t             cls_front;

  trcm_front u_front (
    .clk_i     (clk_i),
    .en_i      (en[FrontStages-1:0]),
    .ax_i      (ax_i),
    .ay_i      (ay_i),
    .bx_i      (bx_i),
    .by_i      (by_i),
    .cx_i      (cx_i),
    .cy_i      (cy_i),
    .side_ab_o (side_ab),
    .side_bc_o (side_bc),
    .side_ca_o (side_ca),
    .cls_o     (cls_front)
  );

  // side length roots
  logic [RootStages-1:0] root_en;
  logic [RootW-1:0]      root_ab, root_bc, root_ca;

  assign root_en = en[FrontStages +: RootStages];

  trcm_isqrt u_sqrt_ab (.clk_i(clk_i), .en_i(root_en), .val_i(side_ab), .root_o(root_ab));
  trcm_isqrt u_sqrt_bc (.clk_i(clk_i), .en_i(root_en), .val_i(side_bc), .root_o(root_bc));
  trcm_isqrt u_sqrt_ca (.clk_i(clk_i), .en_i(root_en), .val_i(side_ca), .root_o(root_ca));

  // classification rides alongside the root stages
  cls_t cls_q [RootStages];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < RootStages; s++) begin
      if (root_en[s]) begin
        cls_q[s] <= (s == 0) ? cls_front : cls_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // result word
  logic [PerimW-1:0] perim_d, perim_q;
  kind_e             kind_q;
  logic [AreaW-1:0]  area_q;

  always_comb begin
    perim_d = PerimW'(root_ab) + PerimW'(root_bc) + PerimW'(root_ca);
    if (cls_q[RootStages-1].kind == KIND_DEGENERATE) begin
      perim_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      perim_q <= perim_d;
      kind_q  <= cls_q[RootStages-1].kind;
      area_q  <= cls_q[RootStages-1].area;
    end
  end

  assign kind_o      = kind_q;
  assign perimeter_o = perim_q;
  assign area_o      = area_q;

  // checks
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DEGENERATE) |-> (perimeter_o == '0) && (area_o == '0))
    else $error("degenerate word with nonzero measure");

  a_nondegen_perim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_DEGENERATE) |-> (perimeter_o >= PerimW'(3)))
    else $error("real triangle with perimeter below three units");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output word");

endmodule
